// ===== rtl/clri_pkg.sv =====
package clri_pkg;

  // Default geometry
  localparam int DEF_MAX_STOPS     = 16;
  localparam int DEF_TABLE_ENTRIES = 256;

  // Fixed field widths
  localparam int SLOT_W       = 4;
  localparam int CHAN_W       = 8;
  localparam int RGB_W        = 3 * CHAN_W;
  localparam int IDX_W        = 9;
  localparam int OUT_W        = 16;
  localparam int NUM_CHAN     = 3;
  localparam int STOP_COUNT_W = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 24;

  localparam logic [STOP_COUNT_W-1:0] STOP_COUNT_RST = STOP_COUNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_COUNT = 1'b0,
    CFG_BACKGROUND = 1'b1
  } clri_cfg_idx_e;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_LOOKUP = 1'b1
  } clri_mode_e;

  // One word in flight: a stop load or a lookup
  typedef struct packed {
    logic              lookup;
    logic              bg;
    logic [SLOT_W-1:0] slot;
    logic [RGB_W-1:0]  rgb;
  } clri_item_t;

  // One result as held in the output queue
  typedef struct packed {
    logic                               bg;
    logic [NUM_CHAN-1:0][OUT_W-1:0]     chan;
  } clri_res_t;

endpackage

// ===== rtl/clri_ram.sv =====
module clri_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/clri_seg_div.sv =====
// Pipelined position / segment-length divider, one quotient bit a stage,
// then segment select with the last segment clamp.
module clri_seg_div #(
  parameter int PW = 8,
  parameter int AW = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  clri_pkg::clri_item_t   item_i,
  input  logic [PW-1:0]          pos_i,
  input  logic [PW-1:0]          seglen_i,
  input  logic [PW-1:0]          lstart_i,
  input  logic [PW-1:0]          llen_i,
  input  logic [AW-1:0]          segm2_i,
  output logic                   vld_o,
  output clri_pkg::clri_item_t   item_o,
  output logic [AW-1:0]          seg_o,
  output logic [PW-1:0]          d_o,
  output logic [PW-1:0]          len_o
);

  logic                 vld_q  [PW];
  clri_pkg::clri_item_t item_q [PW];
  logic [PW-1:0]        pos_q  [PW];
  logic [PW-1:0]        rem_q  [PW];
  logic [PW-1:0]        quo_q  [PW];

  for (genvar k = 0; k < PW; k++) begin : g_stage
    logic                 prev_vld;
    clri_pkg::clri_item_t prev_item;
    logic [PW-1:0]        prev_pos;
    logic [PW-1:0]        prev_rem;
    logic [PW-1:0]        prev_quo;
    logic [PW:0]          trial;
    logic [PW:0]          diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign prev_vld  = vld_i;
      assign prev_item = item_i;
      assign prev_pos  = pos_i;
      assign prev_rem  = '0;
      assign prev_quo  = '0;
    end else begin : g_next
      assign prev_vld  = vld_q[k-1];
      assign prev_item = item_q[k-1];
      assign prev_pos  = pos_q[k-1];
      assign prev_rem  = rem_q[k-1];
      assign prev_quo  = quo_q[k-1];
    end

    assign trial = {prev_rem, prev_pos[PW-1-k]};
    assign diff  = trial - {1'b0, seglen_i};
    assign take  = trial >= {1'b0, seglen_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k] <= prev_item;
        pos_q[k]  <= prev_pos;
        rem_q[k]  <= take ? diff[PW-1:0] : trial[PW-1:0];
        quo_q[k]  <= {prev_quo[PW-2:0], take};
      end
    end
  end

  // Segment select: quotients at or past the second-last stop fall in the last segment
  logic                 is_last;
  logic [PW-1:0]        len_pick;
  logic [AW-1:0]        seg_d;
  logic [PW-1:0]        d_d;
  logic [PW-1:0]        len_d;
  logic                 out_vld_q;
  clri_pkg::clri_item_t out_item_q;
  logic [AW-1:0]        seg_q;
  logic [PW-1:0]        d_q;
  logic [PW-1:0]        len_q;

  always_comb begin
    is_last  = 32'(quo_q[PW-1]) >= 32'(segm2_i);
    seg_d    = is_last ? segm2_i : AW'(quo_q[PW-1]);
    d_d      = is_last ? (pos_q[PW-1] - lstart_i) : rem_q[PW-1];
    len_pick = is_last ? llen_i : seglen_i;
    // zero length only for a degenerate ramp; length 1 with d = 0 gives the stop
    len_d    = (len_pick == '0) ? PW'(1) : len_pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[PW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_item_q <= item_q[PW-1];
      seg_q      <= seg_d;
      d_q        <= d_d;
      len_q      <= len_d;
    end
  end

  assign vld_o  = out_vld_q;
  assign item_o = out_item_q;
  assign seg_o  = seg_q;
  assign d_o    = d_q;
  assign len_o  = len_q;

endmodule

// ===== rtl/clri_blend.sv =====
// Per-channel blend: products, sum, then a 16-stage restoring divider by len.
module clri_blend #(
  parameter int PW = 8
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               en_i,
  input  logic                                               vld_i,
  input  logic                                               bg_i,
  input  logic [clri_pkg::RGB_W-1:0]                         lo_i,
  input  logic [clri_pkg::RGB_W-1:0]                         hi_i,
  input  logic [PW-1:0]                                      d_i,
  input  logic [PW-1:0]                                      len_i,
  output logic                                               vld_o,
  output logic                                               bg_o,
  output logic [clri_pkg::NUM_CHAN-1:0][clri_pkg::OUT_W-1:0] quo_o
);

  localparam int CW    = clri_pkg::CHAN_W;
  localparam int NC    = clri_pkg::NUM_CHAN;
  localparam int QW    = clri_pkg::OUT_W;
  localparam int PRODW = CW + PW;

  // Product stage
  logic             m_vld_q;
  logic             m_bg_q;
  logic [PW-1:0]    m_len_q;
  logic [PRODW-1:0] pa_q [NC];
  logic [PRODW-1:0] pb_q [NC];

  // Sum stage
  logic             s_vld_q;
  logic             s_bg_q;
  logic [PW-1:0]    s_len_q;
  logic [PRODW-1:0] sum_q [NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else if (en_i) begin
      m_vld_q <= vld_i;
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_bg_q  <= bg_i;
      m_len_q <= len_i;
      s_bg_q  <= m_bg_q;
      s_len_q <= m_len_q;
    end
  end

  for (genvar ch = 0; ch < NC; ch++) begin : g_mul
    localparam int SH = (NC - 1 - ch) * CW;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[ch]  <= PRODW'(lo_i[SH +: CW]) * PRODW'(len_i - d_i);
        pb_q[ch]  <= PRODW'(hi_i[SH +: CW]) * PRODW'(d_i);
        sum_q[ch] <= pa_q[ch] + pb_q[ch];
      end
    end
  end

  // Divider: numerator is sum * 256; its top PW bits are already below len
  logic          dv_vld_q [QW];
  logic          dv_bg_q  [QW];
  logic [PW-1:0] dv_len_q [QW];
  logic [PW-1:0] rem_q    [NC][QW];
  logic [QW-1:0] low_q    [NC][QW];
  logic [QW-1:0] quo_q    [NC][QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic          prev_vld;
    logic          prev_bg;
    logic [PW-1:0] prev_len;

    if (k == 0) begin : g_first
      assign prev_vld = s_vld_q;
      assign prev_bg  = s_bg_q;
      assign prev_len = s_len_q;
    end else begin : g_next
      assign prev_vld = dv_vld_q[k-1];
      assign prev_bg  = dv_bg_q[k-1];
      assign prev_len = dv_len_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_bg_q[k]  <= prev_bg;
        dv_len_q[k] <= prev_len;
      end
    end

    for (genvar ch = 0; ch < NC; ch++) begin : g_chan
      logic [PW-1:0] prev_rem;
      logic [QW-1:0] prev_low;
      logic [QW-1:0] prev_quo;
      logic [PW:0]   trial;
      logic [PW:0]   diff;
      logic          take;

      if (k == 0) begin : g_first
        assign prev_rem = sum_q[ch][PRODW-1:CW];
        assign prev_low = {sum_q[ch][CW-1:0], {(QW-CW){1'b0}}};
        assign prev_quo = '0;
      end else begin : g_next
        assign prev_rem = rem_q[ch][k-1];
        assign prev_low = low_q[ch][k-1];
        assign prev_quo = quo_q[ch][k-1];
      end

      assign trial = {prev_rem, prev_low[QW-1-k]};
      assign diff  = trial - {1'b0, prev_len};
      assign take  = trial >= {1'b0, prev_len};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[ch][k] <= take ? diff[PW-1:0] : trial[PW-1:0];
          low_q[ch][k] <= prev_low;
          quo_q[ch][k] <= {prev_quo[QW-2:0], take};
        end
      end
    end
  end

  assign vld_o = dv_vld_q[QW-1];
  assign bg_o  = dv_bg_q[QW-1];

  for (genvar ch = 0; ch < NC; ch++) begin : g_out
    assign quo_o[ch] = quo_q[ch][QW-1];
  end

endmodule

// ===== rtl/color_ramp_lut_interpolator.sv =====
// Colour ramp lookup. Load words (mode 0) store an 8-bit RGB stop into a slot
// of a small stop memory and give no result; lookup words (mode 1) give the
// colour at one table position in unsigned Q8.8 per channel, linearly
// interpolated between the two neighbouring stops, which are spaced evenly
// at (TABLE_ENTRIES-1)/(stop_count-1) positions, the last segment running to
// the end of the table. Positions from TABLE_ENTRIES upwards return the
// background colour with is_background set. One word is taken every clock
// while the input is not stalled. A lookup passes through one stage per
// quotient bit of the segment divider, one select stage, the stop memory
// read, a product and a sum stage, sixteen stages of the per-channel Q8.8
// divider and the output queue. Only a full two-word output queue with a
// result waiting behind it stalls the input. Stops must be loaded before
// they are looked up. The user must write configuration only with no word in
// flight; the block does not enforce this. stop_count is clamped to 2..MAX_STOPS.
module color_ramp_lut_interpolator #(
  parameter int MAX_STOPS     = clri_pkg::DEF_MAX_STOPS,
  parameter int TABLE_ENTRIES = clri_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [clri_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [clri_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [clri_pkg::SLOT_W-1:0]       stop_slot_i,
  input  logic [clri_pkg::CHAN_W-1:0]       stop_red_i,
  input  logic [clri_pkg::CHAN_W-1:0]       stop_green_i,
  input  logic [clri_pkg::CHAN_W-1:0]       stop_blue_i,
  input  logic [clri_pkg::IDX_W-1:0]        lookup_index_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [clri_pkg::OUT_W-1:0]        red_out_o,
  output logic [clri_pkg::OUT_W-1:0]        green_out_o,
  output logic [clri_pkg::OUT_W-1:0]        blue_out_o,
  output logic                              is_background_o
);

  localparam int PW     = $clog2(TABLE_ENTRIES);
  localparam int AW     = $clog2(MAX_STOPS);
  localparam int NCODES = 1 << clri_pkg::STOP_COUNT_W;
  localparam int CW     = clri_pkg::CHAN_W;
  localparam int NC     = clri_pkg::NUM_CHAN;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [clri_pkg::STOP_COUNT_W-1:0] stop_count_q;
  logic [clri_pkg::RGB_W-1:0]        bg_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= clri_pkg::STOP_COUNT_RST;
      bg_rgb_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clri_pkg::CFG_STOP_COUNT: begin
          stop_count_q <= cfg_wdata_i[clri_pkg::STOP_COUNT_W-1:0];
        end
        clri_pkg::CFG_BACKGROUND: begin
          bg_rgb_q <= cfg_wdata_i[clri_pkg::RGB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Ramp geometry, one constant row per stop_count code (clamped at
  // elaboration): segment length, start and length of the last segment,
  // and the index of the second-last stop.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] seglen_lut [NCODES];
  logic [PW-1:0] lstart_lut [NCODES];
  logic [PW-1:0] llen_lut   [NCODES];
  logic [AW-1:0] segm2_lut  [NCODES];

  for (genvar v = 0; v < NCODES; v++) begin : g_geo
    localparam int NV  = (v < 2) ? 2 : ((v > MAX_STOPS) ? MAX_STOPS : v);
    localparam int SL0 = (TABLE_ENTRIES - 1) / (NV - 1);
    localparam int SL  = (SL0 == 0) ? 1 : SL0;
    localparam int LS  = (NV - 2) * SL;
    localparam int LL  = (TABLE_ENTRIES - 1 >= LS) ? (TABLE_ENTRIES - 1 - LS) : 0;
    assign seglen_lut[v] = PW'(SL);
    assign lstart_lut[v] = PW'(LS);
    assign llen_lut[v]   = PW'(LL);
    assign segm2_lut[v]  = AW'(NV - 2);
  end

  logic [PW-1:0] seglen;
  logic [PW-1:0] lstart;
  logic [PW-1:0] llen;
  logic [AW-1:0] segm2;

  assign seglen = seglen_lut[stop_count_q];
  assign lstart = lstart_lut[stop_count_q];
  assign llen   = llen_lut[stop_count_q];
  assign segm2  = segm2_lut[stop_count_q];

  // ---------------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves unless a result sits at its end
  // with the output queue full. No path from out_ready_i to in_ready_o.
  // ---------------------------------------------------------------------------
  logic       adv;
  logic       bl_vld;
  logic [1:0] cnt_q;

  assign adv        = !(bl_vld && (cnt_q == 2'd2));
  assign in_ready_o = adv;

  // ---------------------------------------------------------------------------
  // Input word and segment divider
  // ---------------------------------------------------------------------------
  clri_pkg::clri_item_t in_item;

  always_comb begin
    in_item.lookup = (mode_i == clri_pkg::MODE_LOOKUP);
    in_item.bg     = 32'(lookup_index_i) >= 32'(TABLE_ENTRIES);
    in_item.slot   = stop_slot_i;
    in_item.rgb    = {stop_red_i, stop_green_i, stop_blue_i};
  end

  logic                 sd_vld;
  clri_pkg::clri_item_t sd_item;
  logic [AW-1:0]        sd_seg;
  logic [PW-1:0]        sd_d;
  logic [PW-1:0]        sd_len;

  clri_seg_div #(
    .PW (PW),
    .AW (AW)
  ) u_seg_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (in_valid_i && adv),
    .item_i   (in_item),
    .pos_i    (PW'(lookup_index_i)),
    .seglen_i (seglen),
    .lstart_i (lstart),
    .llen_i   (llen),
    .segm2_i  (segm2),
    .vld_o    (sd_vld),
    .item_o   (sd_item),
    .seg_o    (sd_seg),
    .d_o      (sd_d),
    .len_o    (sd_len)
  );

  // ---------------------------------------------------------------------------
  // Stop memory. Loads write at the same stage where lookups read, so every
  // lookup sees exactly the loads that came before it in word order. Two
  // copies give the two neighbouring stops in the same cycle.
  // ---------------------------------------------------------------------------
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] hi_raddr;
  logic [clri_pkg::RGB_W-1:0] lo_rgb;
  logic [clri_pkg::RGB_W-1:0] hi_rgb;

  assign st_we    = adv && sd_vld && !sd_item.lookup
                    && (32'(sd_item.slot) < 32'(MAX_STOPS));
  assign st_waddr = AW'(sd_item.slot);
  assign hi_raddr = sd_seg + AW'(1);

  clri_ram #(
    .WIDTH (clri_pkg::RGB_W),
    .DEPTH (MAX_STOPS)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (sd_item.rgb),
    .re_i    (adv),
    .raddr_i (sd_seg),
    .rdata_o (lo_rgb)
  );

  clri_ram #(
    .WIDTH (clri_pkg::RGB_W),
    .DEPTH (MAX_STOPS)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (sd_item.rgb),
    .re_i    (adv),
    .raddr_i (hi_raddr),
    .rdata_o (hi_rgb)
  );

  // Control alongside the memory read; loads end here
  logic          rd_vld_q;
  logic          rd_bg_q;
  logic [PW-1:0] rd_d_q;
  logic [PW-1:0] rd_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (adv) begin
      rd_vld_q <= sd_vld && sd_item.lookup;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_bg_q  <= sd_item.bg;
      rd_d_q   <= sd_d;
      rd_len_q <= sd_len;
    end
  end

  // ---------------------------------------------------------------------------
  // Interpolation
  // ---------------------------------------------------------------------------
  logic                          bl_bg;
  logic [NC-1:0][clri_pkg::OUT_W-1:0] bl_quo;

  clri_blend #(
    .PW (PW)
  ) u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (rd_vld_q),
    .bg_i   (rd_bg_q),
    .lo_i   (lo_rgb),
    .hi_i   (hi_rgb),
    .d_i    (rd_d_q),
    .len_i  (rd_len_q),
    .vld_o  (bl_vld),
    .bg_o   (bl_bg),
    .quo_o  (bl_quo)
  );

  // Background colour replaces the interpolated one past the table
  clri_pkg::clri_res_t push_res;

  always_comb begin
    push_res.bg = bl_bg;
    for (int ch = 0; ch < NC; ch++) begin
      push_res.chan[ch] = bl_bg ? {bg_rgb_q[(NC-1-ch)*CW +: CW], {CW{1'b0}}}
                                : bl_quo[ch];
    end
  end

  // ---------------------------------------------------------------------------
  // Two-word output queue
  // ---------------------------------------------------------------------------
  clri_pkg::clri_res_t res_q [2];
  logic                wr_ptr_q;
  logic                rd_ptr_q;
  logic                push;
  logic                pop;

  assign push = adv && bl_vld;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_ptr_q] <= push_res;
    end
  end

  assign out_valid_o     = (cnt_q != 2'd0);
  assign red_out_o       = res_q[rd_ptr_q].chan[0];
  assign green_out_o     = res_q[rd_ptr_q].chan[1];
  assign blue_out_o      = res_q[rd_ptr_q].chan[2];
  assign is_background_o = res_q[rd_ptr_q].bg;

endmodule

// ===== bench/color_ramp_lut_interpolator_tb.sv =====
module color_ramp_lut_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clri_pkg::*;

  // Drain wait: longer than the block's own pipeline, with a little margin on top
  localparam int DRAIN_CYCLES = 40;
  // Length of the long receiver hold-off that backs the pipe up to the input
  localparam int HOLD_CYCLES  = 300;
  localparam int LAST_POS     = DEF_TABLE_ENTRIES - 1;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 100;

  // One input word as queued for the driver
  typedef struct {
    clri_mode_e        mode;
    logic [SLOT_W-1:0] slot;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [IDX_W-1:0]  index;
  } ramp_word_t;

  // One result word, packed so that it compares in a single expression
  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic             bg;
  } colour_t;

  // Every input of the block holds a known value from time zero
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i    = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic                    mode_i         = 1'b0;
  logic [SLOT_W-1:0]       stop_slot_i    = '0;
  logic [CHAN_W-1:0]       stop_red_i     = '0;
  logic [CHAN_W-1:0]       stop_green_i   = '0;
  logic [CHAN_W-1:0]       stop_blue_i    = '0;
  logic [IDX_W-1:0]        lookup_index_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [OUT_W-1:0]        red_out_o;
  logic [OUT_W-1:0]        green_out_o;
  logic [OUT_W-1:0]        blue_out_o;
  logic                    is_background_o;

  // Words waiting for the driver, and colours waiting for the block to return them
  ramp_word_t  pending_words[$];
  colour_t     expected_colours[$];
  int unsigned mismatch_count = 0;

  // Idle and stall rates in percent, plus the long hold-off flag
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold      = 1'b0;

  // Mirror of the block's state: stops and the two registers
  logic [RGB_W-1:0]        stop_mem [DEF_MAX_STOPS];
  logic [STOP_COUNT_W-1:0] stops_cfg = STOP_COUNT_RST;
  logic [RGB_W-1:0]        bg_cfg    = '0;

  color_ramp_lut_interpolator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .stop_slot_i     (stop_slot_i),
    .stop_red_i      (stop_red_i),
    .stop_green_i    (stop_green_i),
    .stop_blue_i     (stop_blue_i),
    .lookup_index_i  (lookup_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .is_background_o (is_background_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Q8.8 blend of two 8-bit channel values, truncated: 256*(a*(len-d)+b*d)/len
  function automatic logic [OUT_W-1:0] mix_channel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                                   int unsigned d, int unsigned seg_len);
    longint unsigned num;
    num = 64'd256 * (64'(a) * 64'(seg_len - d) + 64'(b) * 64'(d));
    return OUT_W'(num / 64'(seg_len));
  endfunction

  // Colour at one ramp position under the current stop count and background
  function automatic colour_t ramp_colour(logic [IDX_W-1:0] pos);
    int unsigned n, seglen, seg, seg_lo, seg_len, d;
    logic [RGB_W-1:0] lo, hi;
    colour_t c;
    // past the table: background bytes, scaled to Q8.8
    if (pos >= DEF_TABLE_ENTRIES) begin
      c.red   = {bg_cfg[2*CHAN_W +: CHAN_W], 8'h00};
      c.green = {bg_cfg[CHAN_W +: CHAN_W], 8'h00};
      c.blue  = {bg_cfg[0 +: CHAN_W], 8'h00};
      c.bg    = 1'b1;
      return c;
    end
    // stop count clamps to 2..MAX_STOPS
    n = stops_cfg;
    if (n < 2) n = 2;
    if (n > DEF_MAX_STOPS) n = DEF_MAX_STOPS;
    seglen = LAST_POS / (n - 1);
    if (seglen == 0) seglen = 1;
    seg = pos / seglen;
    if (seg > n - 2) seg = n - 2;
    seg_lo  = seg * seglen;
    // the final segment stretches to the last table position
    seg_len = (seg + 1 == n - 1) ? LAST_POS - seg_lo : seglen;
    d       = pos - seg_lo;
    lo = stop_mem[SLOT_W'(seg)];
    hi = stop_mem[SLOT_W'(seg + 1)];
    c.red   = mix_channel(lo[2*CHAN_W +: CHAN_W], hi[2*CHAN_W +: CHAN_W], d, seg_len);
    c.green = mix_channel(lo[CHAN_W +: CHAN_W], hi[CHAN_W +: CHAN_W], d, seg_len);
    c.blue  = mix_channel(lo[0 +: CHAN_W], hi[0 +: CHAN_W], d, seg_len);
    c.bg    = 1'b0;
    return c;
  endfunction

  function automatic ramp_word_t load_word(logic [SLOT_W-1:0] slot, logic [RGB_W-1:0] rgb);
    ramp_word_t w;
    w.mode  = MODE_LOAD;
    w.slot  = slot;
    w.red   = rgb[2*CHAN_W +: CHAN_W];
    w.green = rgb[CHAN_W +: CHAN_W];
    w.blue  = rgb[0 +: CHAN_W];
    w.index = IDX_W'($urandom);   // ignored by a load
    return w;
  endfunction

  function automatic ramp_word_t lookup_word(logic [IDX_W-1:0] pos);
    ramp_word_t w;
    w       = load_word(SLOT_W'($urandom), RGB_W'($urandom));  // stop fields are noise here
    w.mode  = MODE_LOOKUP;
    w.index = pos;
    return w;
  endfunction

  // Random traffic: mostly lookups inside the table, some past it, some stop reloads.
  // All slots are written up front, so no lookup can ever touch an unwritten stop.
  function automatic ramp_word_t random_word();
    if ($urandom_range(99) < 25)
      return load_word(SLOT_W'($urandom), RGB_W'($urandom));
    if ($urandom_range(99) < 80)
      return lookup_word(IDX_W'($urandom_range(LAST_POS)));
    return lookup_word(IDX_W'($urandom_range(511, DEF_TABLE_ENTRIES)));
  endfunction

  // Register write: one cycle of write enable, mirror updated once it has landed
  task automatic write_reg(clri_cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_STOP_COUNT)
      stops_cfg = data[STOP_COUNT_W-1:0];
    else
      bg_cfg = data[RGB_W-1:0];
  endtask

  // Wait until every word has gone in and every colour has come back, then let
  // trailing loads (which give no result) clear the pipe before anything changes
  task automatic wait_drained();
    do
      @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_colours.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Driver: holds a word steady until taken, then offers the next or idles
  always @(posedge clk_i or negedge rst_ni) begin
    ramp_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_valid_i     <= 1'b1;
        mode_i         <= w.mode;
        stop_slot_i    <= w.slot;
        stop_red_i     <= w.red;
        stop_green_i   <= w.green;
        stop_blue_i    <= w.blue;
        lookup_index_i <= w.index;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and a stall throughout the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each returned colour against the oldest prediction, and
  // predicts from each word the block takes (loads update the stop mirror)
  always @(posedge clk_i) begin
    colour_t got;
    colour_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{red: red_out_o, green: green_out_o, blue: blue_out_o, bg: is_background_o};
        if (expected_colours.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result r=%h g=%h b=%h bg=%b", $realtime,
                     got.red, got.green, got.blue, got.bg);
        end else begin
          want = expected_colours.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp r=%h g=%h b=%h bg=%b, got r=%h g=%h b=%h bg=%b",
                       $realtime, want.red, want.green, want.blue, want.bg,
                       got.red, got.green, got.blue, got.bg);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (mode_i == MODE_LOAD)
          stop_mem[stop_slot_i] = {stop_red_i, stop_green_i, stop_blue_i};
        else
          expected_colours.push_back(ramp_colour(lookup_index_i));
      end
    end
  end

  // Hard limit, far beyond the slowest correct run
  initial begin
    #1ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [4:0]        count_plan;
    logic [RGB_W-1:0]  bg_plan;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset stop count written explicitly, then a white background
    write_reg(CFG_STOP_COUNT, CFG_DATA_W'(2));
    write_reg(CFG_BACKGROUND, 24'hFFFFFF);

    // Directed: fill every slot (extremes at the ends of the ramp), then probe
    // the table ends, the segment middle, the first background index and the
    // largest index
    pending_words.push_back(load_word(4'd0, 24'h000000));
    pending_words.push_back(load_word(4'd1, 24'hFFFFFF));
    for (int s = 2; s < DEF_MAX_STOPS - 1; s++)
      pending_words.push_back(load_word(SLOT_W'(s), RGB_W'($urandom)));
    pending_words.push_back(load_word(4'hF, 24'hFF00FF));
    pending_words.push_back(lookup_word(9'd0));
    pending_words.push_back(lookup_word(9'd1));
    pending_words.push_back(lookup_word(9'd127));
    pending_words.push_back(lookup_word(9'd254));
    pending_words.push_back(lookup_word(9'd255));
    pending_words.push_back(lookup_word(9'd256));
    pending_words.push_back(lookup_word(9'd511));
    pending_words.push_back(lookup_word(9'd300));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      // Stop counts cover both clamps (0, 1, 17, 31) and both legal ends
      case (ph)
        0:       count_plan = 5'd2;
        1:       count_plan = 5'd16;
        2:       count_plan = 5'd0;
        3:       count_plan = 5'd1;
        4:       count_plan = 5'd31;
        5:       count_plan = 5'd17;
        default: count_plan = 5'($urandom_range(15, 3));
      endcase
      case (ph)
        0:       bg_plan = 24'h000000;
        1:       bg_plan = 24'hFFFFFF;
        default: bg_plan = RGB_W'($urandom);
      endcase
      write_reg(CFG_STOP_COUNT, CFG_DATA_W'(count_plan));
      write_reg(CFG_BACKGROUND, CFG_DATA_W'(bg_plan));

      // Idling pattern rotates: none, sender, receiver, both lightly
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase

      for (int i = 0; i < PHASE_WORDS; i++)
        pending_words.push_back(random_word());

      // Once, with the sender flat out, the receiver holds off long enough for
      // the output queue and the pipe to fill and stall the input
      if (ph == 4)
        fork
          begin
            long_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk_i);
            long_hold = 1'b0;
          end
        join_none

      wait_drained();
    end

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
